// ----- design/ire_pkg.sv -----
// Shared types, constants and key lookup for the IR remote edge decoder.
// No dependencies; used by every other design file.
package ire_pkg;

  localparam int unsigned INTERVAL_W = 20;
  localparam int unsigned UNIT_W     = 10;
  localparam int unsigned FLEN_W     = 7;
  localparam int unsigned WORD_W     = 64;
  localparam int unsigned QUOT_W     = 3;
  localparam int unsigned KEY_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = UNIT_W;

  localparam logic [UNIT_W-1:0] UNIT_TIME_RST = UNIT_W'(400);
  localparam logic [FLEN_W-1:0] FRAME_LEN_RST = FLEN_W'(83);

  localparam logic [QUOT_W-1:0] HEADER_UNITS = QUOT_W'(6);
  localparam logic [QUOT_W-1:0] IGNORE_UNITS = QUOT_W'(7);

  localparam logic [WORD_W-1:0] EVEN_BITS_MASK = 64'h5555_5555_5555_5555;
  localparam logic [23:0]       KEY_OK_CODE    = 24'h100404;
  localparam logic [23:0]       KEY_BACK_CODE  = 24'h100405;
  localparam logic [23:0]       KEY_SKIP_CODE  = 24'h100144;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UNIT_TIME = 1'b0,
    REG_FRAME_LEN = 1'b1
  } cfg_reg_t;

  typedef enum logic [KEY_W-1:0] {
    KEY_NONE = 2'd0,
    KEY_OK   = 2'd1,
    KEY_BACK = 2'd2,
    KEY_SKIP = 2'd3
  } key_t;

  typedef struct packed {
    logic load;
    logic step;
    logic prep;
    logic shift;
    logic store;
    logic emit;
  } ire_cmd_t;

  typedef struct packed {
    logic div_done;
    logic ignored;
    logic shift_zero;
    logic hit;
    logic slot_free;
  } ire_sts_t;

  function automatic key_t ire_key(input logic [23:0] low);
    key_t k;
    k = KEY_NONE;
    if (low == KEY_OK_CODE) begin
      k = KEY_OK;
    end else if (low == KEY_BACK_CODE) begin
      k = KEY_BACK;
    end else if (low == KEY_SKIP_CODE) begin
      k = KEY_SKIP;
    end
    return k;
  endfunction

endpackage

// ----- design/ire_ifs.sv -----
// Valid/ready channel interfaces: edge input, frame result and register write.
// Depends on ire_pkg for field widths.
interface ire_in_if;
  logic                             valid;
  logic                             ready;
  logic [ire_pkg::INTERVAL_W-1:0]   interval_us;
  modport source (output valid, output interval_us, input ready);
  modport sink   (input valid, input interval_us, output ready);
endinterface

interface ire_out_if;
  logic                             valid;
  logic                             ready;
  logic [ire_pkg::WORD_W-1:0]       frame_word;
  logic                             toggle_clear;
  logic [ire_pkg::KEY_W-1:0]        key_code;
  modport source (output valid, output frame_word, output toggle_clear, output key_code,
                  input ready);
  modport sink   (input valid, input frame_word, input toggle_clear, input key_code,
                  output ready);
endinterface

interface ire_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ire_pkg::CFG_IDX_W-1:0]    idx;
  logic [ire_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, output idx, output data, input ready);
  modport sink   (input valid, input idx, input data, output ready);
endinterface

// ----- design/ire_ctrl.sv -----
// Sequencing FSM: accept, iterative unit divide, per-unit shift, frame finish.
// Depends on ire_pkg command/status structs.
module ire_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ire_pkg::ire_sts_t sts,
  output ire_pkg::ire_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SHIFT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts.div_done) begin
          cmd.step = 1'b1;
        end else if (sts.ignored) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.prep  = 1'b1;
          state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (!sts.shift_zero) begin
          cmd.shift = 1'b1;
        end else if (!sts.hit) begin
          cmd.store = 1'b1;
          state_nxt = ST_IDLE;
        end else if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/ire_dp.sv -----
// Datapath: config registers, divide remainder/quotient, level, sample shift
// register, unit counter and output register. Depends on ire_pkg, ire_ifs.
module ire_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ire_pkg::INTERVAL_W-1:0] interval_us,
  input  ire_pkg::ire_cmd_t              cmd,
  output ire_pkg::ire_sts_t              sts,
  ire_cfg_if.sink                        cfg_ch,
  ire_out_if.source                      out_ch
);

  logic [ire_pkg::UNIT_W-1:0]     unit_time_r;
  logic [ire_pkg::FLEN_W-1:0]     frame_len_r;
  logic                           level_r;
  logic [ire_pkg::WORD_W-1:0]     shift_r;
  logic [ire_pkg::FLEN_W-1:0]     count_r;
  logic [ire_pkg::INTERVAL_W-1:0] rem_r;
  logic [ire_pkg::QUOT_W-1:0]     quot_r;
  logic [ire_pkg::QUOT_W-1:0]     shcnt_r;
  logic [ire_pkg::FLEN_W:0]       total_r;
  logic                           out_valid_r;
  logic [ire_pkg::WORD_W-1:0]     word_r;
  logic                           toggle_r;
  logic [ire_pkg::KEY_W-1:0]      key_r;

  logic [ire_pkg::UNIT_W-1:0]     unit_eff;
  logic                           rem_ge;
  logic                           header;
  logic [ire_pkg::FLEN_W:0]       total_nxt;
  logic [ire_pkg::WORD_W-1:0]     word_nxt;
  logic                           toggle_nxt;

  assign cfg_ch.ready = 1'b1;

  // zero unit time behaves as one
  assign unit_eff  = (unit_time_r == '0) ? ire_pkg::UNIT_W'(1) : unit_time_r;
  assign rem_ge    = rem_r >= ire_pkg::INTERVAL_W'(unit_eff);
  assign header    = quot_r == ire_pkg::HEADER_UNITS;
  assign total_nxt = (header ? '0 : ire_pkg::FLEN_W'(0) + {1'b0, count_r})
                     + (ire_pkg::FLEN_W+1)'(quot_r);
  assign word_nxt   = shift_r & ire_pkg::EVEN_BITS_MASK;
  assign toggle_nxt = word_nxt[31:24] == 8'h00;

  assign sts.ignored    = quot_r == ire_pkg::IGNORE_UNITS;
  assign sts.div_done   = !rem_ge || sts.ignored;
  assign sts.shift_zero = shcnt_r == '0;
  assign sts.hit        = total_r >= {1'b0, frame_len_r};
  assign sts.slot_free  = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_time_r <= ire_pkg::UNIT_TIME_RST;
      frame_len_r <= ire_pkg::FRAME_LEN_RST;
      level_r     <= 1'b0;
      shift_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (ire_pkg::cfg_reg_t'(cfg_ch.idx))
          ire_pkg::REG_UNIT_TIME: unit_time_r <= cfg_ch.data;
          ire_pkg::REG_FRAME_LEN: frame_len_r <= cfg_ch.data[ire_pkg::FLEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        level_r <= ~level_r;
      end
      if (cmd.prep) begin
        if (header) begin
          level_r <= 1'b1;
        end
      end
      if (cmd.shift) begin
        shift_r <= {shift_r[ire_pkg::WORD_W-2:0], level_r};
      end
      if (cmd.store) begin
        count_r <= total_r[ire_pkg::FLEN_W-1:0];
      end
      if (cmd.emit) begin
        count_r     <= '0;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem_r  <= interval_us;
      quot_r <= '0;
    end else if (cmd.step) begin
      rem_r  <= rem_r - ire_pkg::INTERVAL_W'(unit_eff);
      quot_r <= quot_r + ire_pkg::QUOT_W'(1);
    end
    if (cmd.prep) begin
      shcnt_r <= quot_r;
      total_r <= total_nxt;
    end else if (cmd.shift) begin
      shcnt_r <= shcnt_r - ire_pkg::QUOT_W'(1);
    end
    if (cmd.emit) begin
      word_r   <= word_nxt;
      toggle_r <= toggle_nxt;
      key_r    <= toggle_nxt ? ire_pkg::ire_key(word_nxt[23:0]) : ire_pkg::KEY_NONE;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_word   = word_r;
  assign out_ch.toggle_clear = toggle_r;
  assign out_ch.key_code     = key_r;

endmodule

// ----- design/ir_remote_edge_decoder.sv -----
// Top level: IR edge decoder, FSM in ire_ctrl, datapath in ire_dp.
// Per edge: accept, divide by repeated subtraction, a decision, one shift per unit, then a
// finish, where a completed frame waits for a free output slot; one edge in flight.
// Divide is repeated subtraction of unit_time_us; an edge of seven units or more is ignored.
// The result word sits in an output register while the next edge is taken.
// Reset (rst_n low, synchronous): config to 400/83, level, shifter, counter cleared.
module ir_remote_edge_decoder (
  input  logic       clk,
  input  logic       rst_n,
  ire_in_if.sink     in_ch,
  ire_out_if.source  out_ch,
  ire_cfg_if.sink    cfg_ch
);

  ire_pkg::ire_cmd_t cmd;
  ire_pkg::ire_sts_t sts;

  ire_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ire_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .interval_us (in_ch.interval_us),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_ch      (cfg_ch),
    .out_ch      (out_ch)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted twice in a row");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwrote a pending word");

  a_key_needs_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.key_code != ire_pkg::KEY_NONE) |-> out_ch.toggle_clear)
    else $error("key code without toggle flag");

  a_odd_bits_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((out_ch.frame_word & ~ire_pkg::EVEN_BITS_MASK) == '0))
    else $error("odd bits set in frame word");

endmodule

// ----- dv/tb.sv -----
// Testbench for ir_remote_edge_decoder: a directed table of edges and register writes, then
// random edge trains and framed key patterns, each result word checked against an in-bench
// decoder model or a typed row's frame. Depends on ire_pkg, ire_ifs interfaces and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ire_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              toggle;
    key_t              key;
  } frame_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [INTERVAL_W-1:0] iv;
    logic [CFG_DATA_W-1:0] unit_w;
    logic [CFG_DATA_W-1:0] flen_w;
    logic                  typed;
    frame_t                tv;
  } dir_row_t;

  localparam frame_t NO_FRAME = '0;
  localparam int     DIR_N    = 17;
  localparam int     EDGE_GOAL = 1700;
  localparam int     SETTLE_CYC = 20;

  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{1'b0, 20'd0,      10'd0,    10'd0,    1'b0, NO_FRAME},
    '{1'b0, 20'd999999, 10'd0,    10'd0,    1'b0, NO_FRAME},
    '{1'b0, 20'd2800,   10'd0,    10'd0,    1'b0, NO_FRAME},
    '{1'b0, 20'd2799,   10'd0,    10'd0,    1'b0, NO_FRAME},
    '{1'b0, 20'd2400,   10'd0,    10'd0,    1'b0, NO_FRAME},
    '{1'b0, 20'd399,    10'd0,    10'd0,    1'b0, NO_FRAME},
    // frame length dropped below the stored count
    '{1'b1, 20'd0,      10'd400,  10'd1,    1'b0, NO_FRAME},
    '{1'b0, 20'd0,      10'd0,    10'd0,    1'b1, '{64'h555, 1'b1, KEY_NONE}},
    // zero unit time, zero frame length
    '{1'b1, 20'd0,      10'd0,    10'd0,    1'b0, NO_FRAME},
    '{1'b0, 20'd0,      10'd0,    10'd0,    1'b1, '{64'h555, 1'b1, KEY_NONE}},
    '{1'b0, 20'd5,      10'd0,    10'd0,    1'b1, '{64'h15555, 1'b1, KEY_NONE}},
    '{1'b0, 20'd7,      10'd0,    10'd0,    1'b0, NO_FRAME},
    '{1'b1, 20'd0,      10'd1023, 10'h3FF,  1'b0, NO_FRAME},
    '{1'b0, 20'd1022,   10'd0,    10'd0,    1'b0, NO_FRAME},
    '{1'b0, 20'd6137,   10'd0,    10'd0,    1'b0, NO_FRAME},
    '{1'b0, 20'd6138,   10'd0,    10'd0,    1'b0, NO_FRAME},
    '{1'b0, 20'd999999, 10'd0,    10'd0,    1'b0, NO_FRAME}
  };

  logic clk;
  logic rst_n = 1'b0;

  ire_in_if  edge_bus ();
  ire_out_if frame_bus ();
  ire_cfg_if cfg_bus ();

  ir_remote_edge_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (edge_bus),
    .out_ch (frame_bus),
    .cfg_ch (cfg_bus)
  );

  // decoder model state and register copies
  logic                  level_q   = 1'b0;
  logic [WORD_W-1:0]     shift_q   = '0;
  logic [FLEN_W-1:0]     units_acc = '0;
  logic [UNIT_W-1:0]     unit_cfg  = UNIT_TIME_RST;
  logic [FLEN_W-1:0]     flen_cfg  = FRAME_LEN_RST;

  frame_t frames_due [$];
  int     errors     = 0;
  int     live_edges = 0;
  int     phase_no   = 0;
  int     hold_ask   = 0;
  int     hold_seen  = 0;
  bit     steady     = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int unsigned unit_span();
    return (unit_cfg == '0) ? 1 : int'(unit_cfg);
  endfunction

  function automatic logic decode_edge(input logic [INTERVAL_W-1:0] iv, output frame_t f);
    int unsigned       n;
    logic [7:0]        total;
    logic [WORD_W-1:0] w;
    n = iv / unit_span();
    f = '0;
    level_q = ~level_q;
    if (n >= IGNORE_UNITS) return 1'b0;
    if (n == HEADER_UNITS) begin
      level_q   = 1'b1;
      units_acc = '0;
    end
    repeat (n) shift_q = {shift_q[WORD_W-2:0], level_q};
    total = {1'b0, units_acc} + 8'(n);
    if (total >= {1'b0, flen_cfg}) begin
      w        = shift_q & EVEN_BITS_MASK;
      f.word   = w;
      f.toggle = (w[31:24] == 8'h00);
      f.key    = KEY_NONE;
      if (f.toggle) begin
        case (w[23:0])
          KEY_OK_CODE:   f.key = KEY_OK;
          KEY_BACK_CODE: f.key = KEY_BACK;
          KEY_SKIP_CODE: f.key = KEY_SKIP;
          default:       f.key = KEY_NONE;
        endcase
      end
      units_acc = '0;
      return 1'b1;
    end
    units_acc = total[FLEN_W-1:0];
    return 1'b0;
  endfunction

  function automatic logic [INTERVAL_W-1:0] unit_iv(input int unsigned n);
    int unsigned span;
    span = unit_span();
    return INTERVAL_W'(n * span + $urandom_range(span - 1));
  endfunction

  function automatic logic [INTERVAL_W-1:0] noise_iv();
    if ($urandom_range(4) == 0) return INTERVAL_W'($urandom_range(999999));
    return unit_iv($urandom_range(8));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_unit();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 10'd1;
      2:       return 10'd1023;
      3:       return 10'd400;
      default: return CFG_DATA_W'($urandom_range(1023, 1));
    endcase
  endfunction

  function automatic logic [FLEN_W-1:0] pick_flen();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 7'd1;
      2:       return 7'd127;
      3:       return 7'd83;
      default: return FLEN_W'($urandom_range(127));
    endcase
  endfunction

  function automatic logic [31:0] key_pattern();
    logic [23:0] low;
    logic [7:0]  top;
    case ($urandom_range(4))
      0:       low = KEY_OK_CODE;
      1:       low = KEY_BACK_CODE;
      2:       low = KEY_SKIP_CODE;
      default: low = 24'($urandom);
    endcase
    low = low | (24'($urandom) & 24'hAAAAAA);
    top = ($urandom_range(3) != 0) ? (8'($urandom) & 8'hAA) : 8'($urandom);
    return {top, low};
  endfunction

  task automatic send_edge(input logic [INTERVAL_W-1:0] iv, input logic typed = 1'b0,
                           input frame_t tv = '0);
    frame_t f;
    while (!steady && $urandom_range(99) < 37) begin
      edge_bus.valid <= 1'b0;
      @(posedge clk);
    end
    live_edges++;
    if (decode_edge(iv, f) || typed) frames_due.push_back(typed ? tv : f);
    edge_bus.valid       <= 1'b1;
    edge_bus.interval_us <= iv;
    do @(posedge clk); while (!edge_bus.ready);
  endtask

  // header, then runs of at most five units; zero-unit edges realign the level
  task automatic send_frame(input logic [31:0] pat);
    int   i;
    int   n;
    logic b;
    logic lvl;
    send_edge(unit_iv(HEADER_UNITS));
    lvl = 1'b1;
    i   = 31;
    while (i >= 0) begin
      b = pat[i];
      n = 0;
      while (i >= 0 && pat[i] == b && n < 5) begin
        n++;
        i--;
      end
      if (~lvl != b) begin
        send_edge(unit_iv(0));
        lvl = ~lvl;
      end
      send_edge(unit_iv(n));
      lvl = ~lvl;
    end
  endtask

  task automatic write_regs(input logic [CFG_DATA_W-1:0] unit_w,
                            input logic [CFG_DATA_W-1:0] flen_w);
    cfg_bus.valid <= 1'b1;
    cfg_bus.idx   <= REG_UNIT_TIME;
    cfg_bus.data  <= unit_w;
    do @(posedge clk); while (!cfg_bus.ready);
    unit_cfg = unit_w;
    cfg_bus.idx  <= REG_FRAME_LEN;
    cfg_bus.data <= flen_w;
    do @(posedge clk); while (!cfg_bus.ready);
    flen_cfg = flen_w[FLEN_W-1:0];
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain_frames();
    edge_bus.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  initial begin
    frame_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        frame_bus.ready <= 1'b0;
      end else if (hold_seen != hold_ask) begin
        hold_seen = hold_ask;
        frame_bus.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else begin
        frame_bus.ready <= steady || ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk) begin
    frame_t want;
    if (rst_n && frame_bus.valid && frame_bus.ready) begin
      if (frames_due.size() == 0) begin
        $error("frame_word: none expected, got %h", frame_bus.frame_word);
        errors++;
      end else begin
        want = frames_due.pop_front();
        if (frame_bus.frame_word !== want.word) begin
          $error("frame_word: expected %h, got %h", want.word, frame_bus.frame_word);
          errors++;
        end
        if (frame_bus.toggle_clear !== want.toggle) begin
          $error("toggle_clear: expected %b, got %b", want.toggle, frame_bus.toggle_clear);
          errors++;
        end
        if (frame_bus.key_code !== want.key) begin
          $error("key_code: expected %0d, got %0d", want.key, frame_bus.key_code);
          errors++;
        end
      end
    end
  end

  initial begin
    edge_bus.valid       <= 1'b0;
    edge_bus.interval_us <= '0;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.idx          <= REG_UNIT_TIME;
    cfg_bus.data         <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].is_cfg) begin
        drain_frames();
        write_regs(DIR_TAB[i].unit_w, DIR_TAB[i].flen_w);
      end else begin
        send_edge(DIR_TAB[i].iv, DIR_TAB[i].typed, DIR_TAB[i].tv);
      end
    end

    live_edges = 0;
    while (live_edges < EDGE_GOAL) begin
      phase_no++;
      drain_frames();
      steady = (phase_no == 4);
      if (phase_no == 6) begin
        // every edge of one to six units completes a frame while the sink holds off
        write_regs(pick_unit(), 10'd1);
        hold_ask++;
        repeat (40) send_edge(noise_iv());
      end else if ($urandom_range(3) != 0) begin
        write_regs(pick_unit(), {3'($urandom_range(7)), 7'd38});
        repeat (6) begin
          if ($urandom_range(7) == 0) send_edge(noise_iv());
          send_frame(key_pattern());
        end
      end else begin
        write_regs(pick_unit(), {3'($urandom_range(7)), pick_flen()});
        repeat (50) send_edge(noise_iv());
      end
    end
    steady = 1'b0;

    drain_frames();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
